[hw/rtl/lfu_pkg.sv]
`timescale 1ns / 1ps
package lfu_pkg;
   localparam int Entries = 16;
   localparam int SlotW = $clog2(Entries + 1);
   localparam int IdxW = $clog2(Entries);
   localparam logic [SlotW-1:0] Nil = SlotW'(Entries);
   localparam logic [15:0] UsesMax = 16'hFFFF;
   localparam int EntryW = 32 + 16 + 16 + SlotW + SlotW;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_PRV_RD,
      ST_PRV_WR,
      ST_NXT_RD,
      ST_NXT_WR,
      ST_APP_RD,
      ST_APP_TAIL,
      ST_APP_NEW,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0]      key;
      logic [15:0]      handle;
      logic [15:0]      uses;
      logic [SlotW-1:0] next;
      logic [SlotW-1:0] prev;
   } entry_type;
endpackage

[hw/rtl/lfu_ram.sv]
`timescale 1ns / 1ps
module lfu_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/lfu_connection_table_core.sv]
`timescale 1ns / 1ps
// Flow after acceptance: an insert with a free slot appends at once; an insert into a full
// table walks every entry for the least used one, unlinks it and appends into its slot; a
// lookup or remove walks until its hit (a remove then unlinks) or the end; the unused op code answers at once.
// Throughput: one request at a time, the next accepted in the cycle after the result is
// registered; each linked entry costs a read state and a check state of the entry memory.
// Reset: synchronous, active high; empties the order list and rebuilds the free stack.
module lfu_connection_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tuser: op[1:0].
   input  logic [1:0]  req_tuser,
   // tdata: ip_key[31:0], handle[47:32].
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: found[0], handle_out[16:1], evicted[17], evicted_handle[33:18], zero fill.
   output logic [39:0] rsp_tdata
);
   import lfu_pkg::*;

   // Request fields captured at acceptance.
   op_type           req_op;
   op_type           op_ff;
   logic [31:0]      key_ff;
   logic [15:0]      hdl_ff;

   // Walk state.
   state_type        state_ff, state_in;
   logic [SlotW-1:0] cur_ff, cur_in;
   logic [SlotW-1:0] victim_ff, victim_in;
   logic [16:0]      min_ff, min_in;
   logic [SlotW-1:0] steps_ff, steps_in;
   entry_type        vic_ff, vic_in;    // copy of the entry being unlinked

   // List heads and the free stack. The free links are one flip-flop word per slot,
   // so reset rebuilds the stack at once and no clearing pass is needed.
   logic [SlotW-1:0] head_ff, head_in, tail_ff, tail_in, free_top_ff;
   logic [SlotW-1:0] free_link_ff [Entries];
   logic             free_push, free_pop;

   // Working result fields and the result register that drives the port.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [39:0]      rsp_data_ff, rsp_data_in;
   logic             found_ff, found_in, ev_ff, ev_in;
   logic [15:0]      hout_ff, hout_in, evh_ff, evh_in;

   // Memory port.
   logic             wr_en;
   logic [IdxW-1:0]  wr_addr, rd_addr;
   entry_type        wr_data, rd_data;

   lfu_ram #(.Width(EntryW), .Depth(Entries)) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_op     = op_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The walk ends at the null link or after Entries steps.
   logic walk_end;
   assign walk_end = (cur_ff == Nil) || (steps_ff == SlotW'(Entries));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == OP_NONE) begin
                  state_in = ST_DONE;
               end else if (req_op == OP_INSERT && free_top_ff != Nil) begin
                  state_in = ST_APP_RD;
               end else begin
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_WALK_RD: begin
            if (walk_end) begin
               if (op_ff == OP_INSERT && victim_ff != Nil) begin
                  state_in = ST_PRV_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (op_ff == OP_LOOKUP && rd_data.key == key_ff) begin
               state_in = ST_DONE;
            end else if (op_ff == OP_REMOVE && rd_data.handle == hdl_ff) begin
               state_in = ST_PRV_RD;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_PRV_RD:   state_in = ST_PRV_WR;
         ST_PRV_WR:   state_in = ST_NXT_RD;
         ST_NXT_RD:   state_in = ST_NXT_WR;
         ST_NXT_WR:   state_in = (op_ff == OP_INSERT) ? ST_APP_RD : ST_DONE;
         ST_APP_RD:   state_in = ST_APP_TAIL;
         ST_APP_TAIL: state_in = ST_APP_NEW;
         ST_APP_NEW:  state_in = ST_DONE;
         ST_DONE:     state_in = (!rsp_valid_ff || rsp_tready) ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Every read that is used is issued in the state before its use, and never in the cycle that
   // writes the same entry, so the registered read always sees the latest contents.
   always_comb begin
      cur_in       = cur_ff;
      victim_in    = victim_ff;
      min_in       = min_ff;
      steps_in     = steps_ff;
      vic_in       = vic_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_push    = 1'b0;
      free_pop     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      found_in     = found_ff;
      hout_in      = hout_ff;
      ev_in        = ev_ff;
      evh_in       = evh_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff[IdxW-1:0];
      wr_data      = rd_data;
      rd_addr      = cur_ff[IdxW-1:0];
      case (state_ff)
         ST_IDLE: begin
            cur_in    = head_ff;
            victim_in = Nil;
            min_in    = 17'h1FFFF;
            steps_in  = '0;
            found_in  = (req_op == OP_INSERT);
            hout_in   = '0;
            ev_in     = 1'b0;
            evh_in    = '0;
         end
         ST_WALK_RD: begin
            // The eviction is known once the whole list has been seen.
            if (walk_end && op_ff == OP_INSERT && victim_ff != Nil) begin
               ev_in  = 1'b1;
               evh_in = vic_ff.handle;
            end
         end
         ST_WALK_CHK: begin
            steps_in = steps_ff + 1'b1;
            cur_in   = rd_data.next;
            if (op_ff == OP_LOOKUP && rd_data.key == key_ff) begin
               found_in = 1'b1;
               hout_in  = rd_data.handle;
               wr_en    = 1'b1;
               if (rd_data.uses != UsesMax) begin
                  wr_data.uses = rd_data.uses + 1'b1;
               end
            end else if (op_ff == OP_REMOVE && rd_data.handle == hdl_ff) begin
               found_in  = 1'b1;
               victim_in = cur_ff;
               vic_in    = rd_data;
            end else if (op_ff == OP_INSERT && {1'b0, rd_data.uses} < min_ff) begin
               // Strictly lower only, so the oldest of equal counts is kept.
               min_in    = {1'b0, rd_data.uses};
               victim_in = cur_ff;
               vic_in    = rd_data;
            end
         end
         ST_PRV_RD: begin
            rd_addr = vic_ff.prev[IdxW-1:0];
         end
         ST_PRV_WR: begin
            // The previous entry skips over the one that leaves, or the head moves on.
            if (vic_ff.prev != Nil) begin
               wr_en        = 1'b1;
               wr_addr      = vic_ff.prev[IdxW-1:0];
               wr_data.next = vic_ff.next;
            end else begin
               head_in = vic_ff.next;
            end
         end
         ST_NXT_RD: begin
            rd_addr = vic_ff.next[IdxW-1:0];
         end
         ST_NXT_WR: begin
            if (vic_ff.next != Nil) begin
               wr_en        = 1'b1;
               wr_addr      = vic_ff.next[IdxW-1:0];
               wr_data.prev = vic_ff.prev;
            end else begin
               tail_in = vic_ff.prev;
            end
            free_push = 1'b1;
         end
         ST_APP_RD: begin
            rd_addr = tail_ff[IdxW-1:0];
         end
         ST_APP_TAIL: begin
            // The current tail links forward to the slot about to be filled.
            if (tail_ff != Nil) begin
               wr_en        = 1'b1;
               wr_addr      = tail_ff[IdxW-1:0];
               wr_data.next = free_top_ff;
            end
         end
         ST_APP_NEW: begin
            wr_en          = 1'b1;
            wr_addr        = free_top_ff[IdxW-1:0];
            wr_data.key    = key_ff;
            wr_data.handle = hdl_ff;
            wr_data.uses   = '0;
            wr_data.prev   = tail_ff;
            wr_data.next   = Nil;
            if (tail_ff == Nil) begin
               head_in = free_top_ff;
            end
            tail_in  = free_top_ff;
            free_pop = 1'b1;
         end
         ST_DONE: begin
            // The result register only loads once the previous result has left.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, evh_ff, ev_ff, hout_ff, found_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= Nil;
         tail_ff      <= Nil;
         free_top_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < Entries; i++) begin
            free_link_ff[i] <= SlotW'(i + 1);
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
         if (free_push) begin
            free_link_ff[victim_ff[IdxW-1:0]] <= free_top_ff;
            free_top_ff <= victim_ff;
         end else if (free_pop) begin
            free_top_ff <= free_link_ff[free_top_ff[IdxW-1:0]];
            free_link_ff[free_top_ff[IdxW-1:0]] <= Nil;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      victim_ff   <= victim_in;
      min_ff      <= min_in;
      steps_ff    <= steps_in;
      vic_ff      <= vic_in;
      found_ff    <= found_in;
      hout_ff     <= hout_in;
      ev_ff       <= ev_in;
      evh_ff      <= evh_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff  <= req_op;
         key_ff <= req_tdata[31:0];
         hdl_ff <= req_tdata[47:32];
      end
   end
endmodule

[hw/rtl/lfu_checker.sv]
`timescale 1ns / 1ps
module lfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");
   a_evict_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tdata[0])
      else $error("eviction without found");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind lfu_connection_table_core lfu_checker u_lfu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
